// ----- rtl/rts_pkg.sv -----
// Package of the retransmit timer scheduler: item codes, queue entry,
// result and configuration types, default parameter values. No dependencies.
`default_nettype none

package rts_pkg;

   localparam int DEF_SEQ_SLOTS = 32;
   localparam int DEF_TICK_BITS = 16;

   // Width used when slot numbers are widened or compared against the slot count
   localparam int IDX_CALC_W = 7;

   localparam logic [7:0] DEF_TIMEOUT_TICKS  = 8'd3;
   localparam logic [7:0] DEF_MAX_IDLE_TICKS = 8'd10;
   localparam logic [7:0] IDLE_SAT           = 8'hFF;

   // Request mode codes as they arrive on the input channel
   localparam logic [1:0] MODE_SEND = 2'd0;
   localparam logic [1:0] MODE_ACK  = 2'd1;
   localparam logic [1:0] MODE_TICK = 2'd2;

   // Configuration register indexes
   localparam logic CSR_TIMEOUT  = 1'b0;
   localparam logic CSR_MAX_IDLE = 1'b1;

   typedef enum logic [1:0] {
      OP_SEND = 2'd0,
      OP_ACK  = 2'd1,
      OP_TICK = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      KIND_TX     = 2'd0,
      KIND_RETX   = 2'd1,
      KIND_STATUS = 2'd2
   } kind_type;

   typedef struct packed {
      op_type     op;
      logic [4:0] seq;
      logic       last_seg;
   } req_item_type;

   typedef struct packed {
      kind_type   kind;
      logic [4:0] packet_seq;
      logic       end_of_message;
      logic       timer_stop;
      logic       last;
   } rsp_item_type;

   typedef struct packed {
      logic [7:0] timeout_ticks;
      logic [7:0] max_idle_ticks;
   } cfg_type;

endpackage

`default_nettype wire

// ----- rtl/rts_if.sv -----
// Channel interfaces of the retransmit timer scheduler: request and result.
// Valid/ready handshake; no dependencies.
`default_nettype none

interface rts_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic [4:0] ack_seq;
   logic       ack_ok;
   logic       last_segment;

   modport source (output valid, output mode, output ack_seq, output ack_ok,
                   output last_segment, input ready);
   modport sink   (input valid, input mode, input ack_seq, input ack_ok,
                   input last_segment, output ready);
endinterface

interface rts_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [4:0] packet_seq;
   logic       end_of_message;
   logic       timer_stop;
   logic       last;

   modport source (output valid, output kind, output packet_seq,
                   output end_of_message, output timer_stop, output last,
                   input ready);
   modport sink   (input valid, input kind, input packet_seq,
                   input end_of_message, input timer_stop, input last,
                   output ready);
endinterface

`default_nettype wire

// ----- rtl/rts_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rts_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/rts_front.sv -----
// Front end: takes requests, classifies them and drops those with no effect.
// Depends on rts_pkg and rts_req_if.
`default_nettype none

module rts_front #(
   parameter int SEQ_SLOTS = rts_pkg::DEF_SEQ_SLOTS
) (
   rts_req_if.sink              req_ch,
   output logic                 push_valid,
   output rts_pkg::req_item_type push_item,
   input  wire logic            push_ready
);
   import rts_pkg::*;

   logic [IDX_CALC_W-1:0] seq_wide;
   logic                  keep;

   assign seq_wide = IDX_CALC_W'(req_ch.ack_seq);

   always_comb begin
      push_item.seq      = req_ch.ack_seq;
      push_item.last_seg = req_ch.last_segment;
      push_item.op       = OP_SEND;
      keep               = 1'b0;
      unique case (req_ch.mode)
         MODE_SEND: begin
            push_item.op = OP_SEND;
            keep         = 1'b1;
         end
         MODE_ACK: begin
            // drop failed acks and slots outside the table
            push_item.op = OP_ACK;
            keep         = req_ch.ack_ok && (seq_wide < IDX_CALC_W'(SEQ_SLOTS));
         end
         MODE_TICK: begin
            push_item.op = OP_TICK;
            keep         = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign req_ch.ready = push_ready;
   assign push_valid   = req_ch.valid && keep;

endmodule

`default_nettype wire

// ----- rtl/rts_queue.sv -----
// Two-entry queue of classified requests between front and back end.
// Depends on rts_pkg.
`default_nettype none

module rts_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push_valid,
   input  wire rts_pkg::req_item_type push_item,
   output logic                       push_ready,
   output logic                       pop_valid,
   output rts_pkg::req_item_type      pop_item,
   input  wire logic                  pop_ready
);
   import rts_pkg::*;

   req_item_type entry_ff [2];
   logic         wr_ptr_ff;
   logic         rd_ptr_ff;
   logic [1:0]   count_ff;
   logic         do_push;
   logic         do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) begin
            entry_ff[wr_ptr_ff] <= push_item;
            wr_ptr_ff           <= ~wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

endmodule

`default_nettype wire

// ----- rtl/rts_back.sv -----
// Back end: slot table, tick timer, scan sequencer and result register.
// Depends on rts_pkg, rts_rsp_if and rts_ram.
`default_nettype none

module rts_back #(
   parameter int SEQ_SLOTS = rts_pkg::DEF_SEQ_SLOTS,
   parameter int TICK_BITS = rts_pkg::DEF_TICK_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire rts_pkg::cfg_type      cfg,
   input  wire logic                  q_valid,
   input  wire rts_pkg::req_item_type q_item,
   output logic                       q_ready,
   rts_rsp_if.source                  rsp_ch
);
   import rts_pkg::*;

   localparam int SLOT_W = $clog2(SEQ_SLOTS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEND,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_STATUS
   } state_type;

   state_type              state_ff;
   req_item_type           item_ff;
   rsp_item_type           out_item_ff;
   logic                   out_vld_ff;
   logic [SLOT_W-1:0]      next_seq_ff;
   logic [TICK_BITS-1:0]   now_ff;
   logic [7:0]             idle_ff;
   logic                   running_ff;
   logic                   sent_ff;
   logic [SEQ_SLOTS-1:0]   used_ff;
   logic [SEQ_SLOTS-1:0]   acked_ff;
   logic [SLOT_W-1:0]      scan_idx_ff;
   logic                   remaining_ff;
   logic                   scan_ff;

   logic                   out_free;
   logic [TICK_BITS-1:0]   stamp;
   logic [TICK_BITS-1:0]   age;
   logic                   pend;
   logic                   hit;
   logic                   scan_end;
   logic [7:0]             idle_new;
   logic                   stop_now;
   logic [IDX_CALC_W-1:0]  ack_wide;
   logic [SLOT_W-1:0]      ack_idx;
   logic [IDX_CALC_W-1:0]  tx_wide;
   logic [IDX_CALC_W-1:0]  retx_wide;
   logic [SLOT_W-1:0]      next_seq_inc;
   logic                   ram_we;

   assign out_free = !out_vld_ff || rsp_ch.ready;
   assign q_ready  = (state_ff == ST_IDLE);

   assign ack_wide  = IDX_CALC_W'(q_item.seq);
   assign ack_idx   = ack_wide[SLOT_W-1:0];
   assign tx_wide   = IDX_CALC_W'(next_seq_ff);
   assign retx_wide = IDX_CALC_W'(scan_idx_ff);

   assign next_seq_inc = (next_seq_ff == SLOT_W'(SEQ_SLOTS - 1)) ? '0
                                                                  : next_seq_ff + SLOT_W'(1);

   assign ram_we = (state_ff == ST_SEND) && out_free;

   rts_ram #(
      .WIDTH (TICK_BITS),
      .DEPTH (SEQ_SLOTS)
   ) u_stamp_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (next_seq_ff),
      .wr_data (now_ff),
      .rd_addr (scan_idx_ff),
      .rd_data (stamp)
   );

   // age wraps with the tick counter
   assign age      = now_ff - stamp;
   assign pend     = used_ff[scan_idx_ff] && !acked_ff[scan_idx_ff];
   assign hit      = pend && (age >= TICK_BITS'(cfg.timeout_ticks));
   assign scan_end = (scan_idx_ff == SLOT_W'(SEQ_SLOTS - 1));

   assign idle_new = (remaining_ff || sent_ff) ? 8'd0 :
                     (idle_ff == IDLE_SAT)     ? idle_ff : idle_ff + 8'd1;
   assign stop_now = (idle_new >= cfg.max_idle_ticks);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_vld_ff   <= 1'b0;
         next_seq_ff  <= '0;
         now_ff       <= '0;
         idle_ff      <= 8'd0;
         running_ff   <= 1'b0;
         sent_ff      <= 1'b0;
         used_ff      <= '0;
         acked_ff     <= '0;
         scan_idx_ff  <= '0;
         remaining_ff <= 1'b0;
         scan_ff      <= 1'b0;
      end else begin
         if (rsp_ch.ready) begin
            out_vld_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  unique case (q_item.op)
                     OP_SEND: begin
                        item_ff  <= q_item;
                        state_ff <= ST_SEND;
                     end
                     OP_ACK: begin
                        acked_ff[ack_idx] <= 1'b1;
                     end
                     OP_TICK: begin
                        now_ff       <= now_ff + TICK_BITS'(1);
                        scan_ff      <= running_ff;
                        scan_idx_ff  <= '0;
                        remaining_ff <= 1'b0;
                        state_ff     <= running_ff ? ST_SCAN_RD : ST_STATUS;
                     end
                     default: begin
                        state_ff <= ST_IDLE;
                     end
                  endcase
               end
            end
            ST_SEND: begin
               if (out_free) begin
                  out_vld_ff                 <= 1'b1;
                  out_item_ff.kind           <= KIND_TX;
                  out_item_ff.packet_seq     <= tx_wide[4:0];
                  out_item_ff.end_of_message <= item_ff.last_seg;
                  out_item_ff.timer_stop     <= 1'b0;
                  out_item_ff.last           <= 1'b1;
                  used_ff[next_seq_ff]       <= 1'b1;
                  acked_ff[next_seq_ff]      <= 1'b0;
                  next_seq_ff                <= next_seq_inc;
                  running_ff                 <= 1'b1;
                  sent_ff                    <= 1'b1;
                  state_ff                   <= ST_IDLE;
               end
            end
            ST_SCAN_RD: begin
               // stamp read in flight
               state_ff <= ST_SCAN_CHK;
            end
            ST_SCAN_CHK: begin
               if (!hit || out_free) begin
                  if (hit) begin
                     out_vld_ff                 <= 1'b1;
                     out_item_ff.kind           <= KIND_RETX;
                     out_item_ff.packet_seq     <= retx_wide[4:0];
                     out_item_ff.end_of_message <= 1'b0;
                     out_item_ff.timer_stop     <= 1'b0;
                     out_item_ff.last           <= 1'b0;
                  end
                  if (pend) begin
                     remaining_ff <= 1'b1;
                  end
                  if (scan_end) begin
                     state_ff <= ST_STATUS;
                  end else begin
                     scan_idx_ff <= scan_idx_ff + SLOT_W'(1);
                     state_ff    <= ST_SCAN_RD;
                  end
               end
            end
            ST_STATUS: begin
               if (out_free) begin
                  out_vld_ff                 <= 1'b1;
                  out_item_ff.kind           <= KIND_STATUS;
                  out_item_ff.packet_seq     <= 5'd0;
                  out_item_ff.end_of_message <= 1'b0;
                  out_item_ff.timer_stop     <= scan_ff ? stop_now : 1'b1;
                  out_item_ff.last           <= 1'b1;
                  if (scan_ff) begin
                     idle_ff <= idle_new;
                     sent_ff <= 1'b0;
                     if (stop_now) begin
                        running_ff <= 1'b0;
                     end
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_ch.valid          = out_vld_ff;
   assign rsp_ch.kind           = out_item_ff.kind;
   assign rsp_ch.packet_seq     = out_item_ff.packet_seq;
   assign rsp_ch.end_of_message = out_item_ff.end_of_message;
   assign rsp_ch.timer_stop     = out_item_ff.timer_stop;
   assign rsp_ch.last           = out_item_ff.last;

   a_scan_idx_range: assert property (@(posedge clock) disable iff (reset)
      scan_idx_ff <= SLOT_W'(SEQ_SLOTS - 1))
      else $error("scan index beyond slot table");

   a_next_seq_range: assert property (@(posedge clock) disable iff (reset)
      next_seq_ff <= SLOT_W'(SEQ_SLOTS - 1))
      else $error("next sequence beyond slot table");

   a_send_starts_timer: assert property (@(posedge clock) disable iff (reset)
      ram_we |=> running_ff && used_ff[$past(next_seq_ff)])
      else $error("send did not mark slot used and start timer");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && !rsp_ch.ready) |=> $stable(out_item_ff))
      else $error("pending result overwritten");

   a_scan_only_running: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN_CHK) |-> (running_ff && scan_ff))
      else $error("slot scan while timer stopped");

endmodule

`default_nettype wire

// ----- rtl/retransmit_timer_scheduler.sv -----
// Top level of the retransmit timer scheduler: configuration registers and
// the front end, request queue and back end. Depends on rts_pkg, rts_if, rts_front, rts_queue and rts_back.
//
//   channel  dir  handshake            carries
//   req_ch   in   valid/ready          mode, ack_seq, ack_ok, last_segment
//   rsp_ch   out  valid/ready          kind, packet_seq, end_of_message,
//                                      timer_stop, last
//   csr_*    in   csr_we, no wait      csr_index, csr_wdata
//
// Back end: a send passes ST_SEND, an ack is done in ST_IDLE, a tick with
// the timer stopped goes to ST_STATUS; with it running, ST_SCAN_RD reads each
// slot's stamp from the stamp RAM and ST_SCAN_CHK checks it, then ST_STATUS.
// A two-entry queue lets requests be taken while the back end works.
// Reset (synchronous) clears all slot flags at once; no clearing pass.
// A stalled result holds the back end; requests keep coming in until the
// queue is full.
`default_nettype none

module retransmit_timer_scheduler #(
   parameter int SEQ_SLOTS = rts_pkg::DEF_SEQ_SLOTS,
   parameter int TICK_BITS = rts_pkg::DEF_TICK_BITS
) (
   input  wire logic       clock,
   input  wire logic       reset,
   rts_req_if.sink         req_ch,
   rts_rsp_if.source       rsp_ch,
   input  wire logic       csr_we,
   input  wire logic       csr_index,
   input  wire logic [7:0] csr_wdata
);
   import rts_pkg::*;

   cfg_type      cfg_ff;
   logic         push_valid;
   req_item_type push_item;
   logic         push_ready;
   logic         pop_valid;
   req_item_type pop_item;
   logic         pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_ticks  <= DEF_TIMEOUT_TICKS;
         cfg_ff.max_idle_ticks <= DEF_MAX_IDLE_TICKS;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TIMEOUT:  cfg_ff.timeout_ticks  <= csr_wdata;
            CSR_MAX_IDLE: cfg_ff.max_idle_ticks <= csr_wdata;
            default:      cfg_ff <= cfg_ff;
         endcase
      end
   end

   rts_front #(
      .SEQ_SLOTS (SEQ_SLOTS)
   ) u_front (
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready)
   );

   rts_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop_ready  (pop_ready)
   );

   rts_back #(
      .SEQ_SLOTS (SEQ_SLOTS),
      .TICK_BITS (TICK_BITS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .q_valid (pop_valid),
      .q_item  (pop_item),
      .q_ready (pop_ready),
      .rsp_ch  (rsp_ch)
   );

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Testbench of the retransmit timer scheduler: a directed table, then random
// phases under several register settings and handshake pressures.
// Depends on rts_pkg, rts_if and retransmit_timer_scheduler.

module tb;
   import rts_pkg::*;

   localparam int SLOTS       = DEF_SEQ_SLOTS;
   localparam int SETTLE      = 200;
   localparam int HOLD_CYCLES = 400;
   localparam int STALL_LIMIT = 5000;
   localparam logic [1:0] MODE_NONE = 2'd3;

   typedef struct packed {
      logic [1:0] mode;
      logic [4:0] ack_seq;
      logic       ack_ok;
      logic       last_segment;
   } request_type;

   typedef struct packed {
      request_type  rq;
      logic         fixed;
      rsp_item_type want;
   } plan_row_type;

   localparam rsp_item_type NO_RSP = '{KIND_TX, 5'd0, 1'b0, 1'b0, 1'b0};
   localparam rsp_item_type IDLE_STOP = '{KIND_STATUS, 5'd0, 1'b0, 1'b1, 1'b1};
   localparam request_type TICK = '{MODE_TICK, 5'd0, 1'b0, 1'b0};

   // Default registers: timeout 3, idle limit 10
   localparam plan_row_type PLAN [24] = '{
      '{TICK, 1'b1, IDLE_STOP},
      '{'{MODE_NONE, 5'd31, 1'b1, 1'b1}, 1'b0, NO_RSP},
      '{'{MODE_SEND, 5'd31, 1'b1, 1'b0}, 1'b1, '{KIND_TX, 5'd0, 1'b0, 1'b0, 1'b1}},
      '{'{MODE_SEND, 5'd0, 1'b0, 1'b1}, 1'b1, '{KIND_TX, 5'd1, 1'b1, 1'b0, 1'b1}},
      '{'{MODE_ACK, 5'd0, 1'b0, 1'b1}, 1'b0, NO_RSP},
      '{'{MODE_ACK, 5'd31, 1'b1, 1'b0}, 1'b0, NO_RSP},
      '{TICK, 1'b0, NO_RSP},
      '{TICK, 1'b0, NO_RSP},
      '{TICK, 1'b0, NO_RSP},
      '{'{MODE_ACK, 5'd0, 1'b1, 1'b0}, 1'b0, NO_RSP},
      '{'{MODE_ACK, 5'd1, 1'b1, 1'b1}, 1'b0, NO_RSP},
      '{TICK, 1'b0, NO_RSP},
      '{TICK, 1'b0, NO_RSP},
      '{TICK, 1'b0, NO_RSP},
      '{TICK, 1'b0, NO_RSP},
      '{TICK, 1'b0, NO_RSP},
      '{TICK, 1'b0, NO_RSP},
      '{TICK, 1'b0, NO_RSP},
      '{TICK, 1'b0, NO_RSP},
      '{TICK, 1'b0, NO_RSP},
      '{TICK, 1'b0, NO_RSP},
      '{TICK, 1'b1, IDLE_STOP},
      '{'{MODE_SEND, 5'd7, 1'b0, 1'b1}, 1'b1, '{KIND_TX, 5'd2, 1'b1, 1'b0, 1'b1}},
      '{TICK, 1'b0, NO_RSP}
   };

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_we;
   logic       csr_index;
   logic [7:0] csr_wdata;

   rts_req_if req_ch ();
   rts_rsp_if rsp_ch ();

   retransmit_timer_scheduler uut (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .rsp_ch   (rsp_ch),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // Predicted slot table and timer
   logic [7:0]  timeout_now = DEF_TIMEOUT_TICKS;
   logic [7:0]  idle_limit_now = DEF_MAX_IDLE_TICKS;
   logic [4:0]  next_slot = '0;
   logic [15:0] tick_now = '0;
   logic [7:0]  idle_run = '0;
   logic        timer_on = 1'b0;
   logic        sent_lately = 1'b0;
   logic        slot_busy [SLOTS];
   logic        slot_acked [SLOTS];
   logic [15:0] slot_stamp [SLOTS];

   rsp_item_type packets_due [$];
   rsp_item_type batch [$];

   int fault_count = 0;
   int gap_pct = 0;
   int stall_pct = 0;
   logic hold_kick = 1'b0;
   logic hold_used = 1'b0;
   int hold_left = 0;
   int quiet_cycles = 0;

   function automatic rsp_item_type packet(kind_type k, logic [4:0] s, logic eom,
                                           logic stop, logic fin);
      rsp_item_type p;
      p.kind           = k;
      p.packet_seq     = s;
      p.end_of_message = eom;
      p.timer_stop     = stop;
      p.last           = fin;
      return p;
   endfunction

   function automatic void forecast_packets(request_type rq);
      logic        unacked;
      logic [15:0] age;
      unacked = 1'b0;
      batch.delete();
      case (rq.mode)
         MODE_SEND: begin
            slot_busy[next_slot]  = 1'b1;
            slot_acked[next_slot] = 1'b0;
            slot_stamp[next_slot] = tick_now;
            timer_on    = 1'b1;
            sent_lately = 1'b1;
            batch.push_back(packet(KIND_TX, next_slot, rq.last_segment, 1'b0, 1'b1));
            next_slot = next_slot + 5'd1;
         end
         MODE_ACK: begin
            if (rq.ack_ok) slot_acked[rq.ack_seq] = 1'b1;
         end
         MODE_TICK: begin
            tick_now = tick_now + 16'd1;
            // a stopped timer only reports; idle count is left alone
            if (timer_on) begin
               for (int i = 0; i < SLOTS; i++) begin
                  if (slot_busy[i] && !slot_acked[i]) begin
                     unacked = 1'b1;
                     age = tick_now - slot_stamp[i];
                     if (age >= timeout_now)
                        batch.push_back(packet(KIND_RETX, 5'(i), 1'b0, 1'b0, 1'b0));
                  end
               end
               if (unacked || sent_lately) idle_run = '0;
               else if (idle_run != IDLE_SAT) idle_run = idle_run + 8'd1;
               sent_lately = 1'b0;
               if (idle_run >= idle_limit_now) timer_on = 1'b0;
            end
            batch.push_back(packet(KIND_STATUS, 5'd0, 1'b0, !timer_on, 1'b1));
         end
         default: ;
      endcase
   endfunction

   task automatic offer(request_type rq, logic fixed, rsp_item_type want);
      while ($urandom_range(99) < gap_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.mode         <= rq.mode;
      req_ch.ack_seq      <= rq.ack_seq;
      req_ch.ack_ok       <= rq.ack_ok;
      req_ch.last_segment <= rq.last_segment;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      forecast_packets(rq);
      if (fixed) batch = '{want};
      foreach (batch[k]) packets_due.push_back(batch[k]);
   endtask

   // Drain every awaited result, then give a trailing ack or tick time to finish
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (packets_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic run_phase(logic [7:0] timeout, logic [7:0] idle_limit, int gap,
                            int stall, int n_items, logic pressure);
      request_type rq;
      int          open_slots [$];
      int          counted;
      int          pick;
      settle();
      csr_we    <= 1'b1;
      csr_index <= CSR_TIMEOUT;
      csr_wdata <= timeout;
      @(posedge clock);
      csr_index <= CSR_MAX_IDLE;
      csr_wdata <= idle_limit;
      @(posedge clock);
      csr_we <= 1'b0;
      timeout_now    = timeout;
      idle_limit_now = idle_limit;
      gap_pct   = gap;
      stall_pct = stall;
      if (pressure) hold_kick = 1'b1;
      counted = 0;
      while (counted < n_items) begin
         rq = request_type'(9'($urandom_range(511)));
         pick = $urandom_range(99);
         if (pick < 35) begin
            rq.mode = MODE_SEND;
         end else if (pick < 65) begin
            rq.mode = MODE_ACK;
            // mostly acknowledge a slot that is really outstanding
            open_slots.delete();
            for (int i = 0; i < SLOTS; i++)
               if (slot_busy[i] && !slot_acked[i]) open_slots.push_back(i);
            if (open_slots.size() != 0 && $urandom_range(9) < 8) begin
               rq.ack_seq = 5'(open_slots[$urandom_range(open_slots.size() - 1)]);
               rq.ack_ok  = 1'b1;
            end
         end else if (pick < 95) begin
            rq.mode = MODE_TICK;
         end else begin
            rq.mode = MODE_NONE;
         end
         offer(rq, 1'b0, NO_RSP);
         if (!(rq.mode == MODE_NONE || (rq.mode == MODE_ACK && !rq.ack_ok)))
            counted++;
      end
   endtask

   // Receiver: random stalls, plus one long hold to back the block up
   always @(posedge clock) begin
      if (hold_kick && !hold_used) begin
         hold_used = 1'b1;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin : check_packets
      rsp_item_type got;
      rsp_item_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = packet(kind_type'(rsp_ch.kind), rsp_ch.packet_seq, rsp_ch.end_of_message,
                      rsp_ch.timer_stop, rsp_ch.last);
         if (packets_due.size() == 0) begin
            fault_count++;
            $display("%0t: expected no packet, got kind %0d seq %0d eom %0b stop %0b last %0b",
                     $time, got.kind, got.packet_seq, got.end_of_message,
                     got.timer_stop, got.last);
         end else begin
            want = packets_due.pop_front();
            if (got.kind !== want.kind || got.packet_seq !== want.packet_seq ||
                got.end_of_message !== want.end_of_message ||
                got.timer_stop !== want.timer_stop || got.last !== want.last) begin
               fault_count++;
               $display("%0t: expected kind %0d seq %0d eom %0b stop %0b last %0b, %s",
                        $time, want.kind, want.packet_seq, want.end_of_message,
                        want.timer_stop, want.last,
                        $sformatf("got kind %0d seq %0d eom %0b stop %0b last %0b",
                                  got.kind, got.packet_seq, got.end_of_message,
                                  got.timer_stop, got.last));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.mode         = MODE_SEND;
      req_ch.ack_seq      = '0;
      req_ch.ack_ok       = 1'b0;
      req_ch.last_segment = 1'b0;
      rsp_ch.ready        = 1'b0;
      csr_we              = 1'b0;
      csr_index           = CSR_TIMEOUT;
      csr_wdata           = '0;
      for (int i = 0; i < SLOTS; i++) begin
         slot_busy[i]  = 1'b0;
         slot_acked[i] = 1'b0;
         slot_stamp[i] = '0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      foreach (PLAN[r]) offer(PLAN[r].rq, PLAN[r].fixed, PLAN[r].want);
      run_phase(8'd1, 8'd1, 0, 0, 20, 1'b0);
      run_phase(8'd255, 8'd255, 87, 0, 15, 1'b0);
      run_phase(8'd0, 8'd0, 0, 87, 20, 1'b0);
      run_phase(8'd2, 8'd3, 7, 7, 20, 1'b0);
      run_phase(8'd5, 8'd255, 0, 0, 25, 1'b1);
      settle();
      if (fault_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
